// ===== rtl/prcg_pkg.sv =====
// Package for the polynomial remap coordinate generator.
// Holds the fixed field widths, the maximum degree, register indexes, the sideband type
// and the Q16 rounding helper. No dependencies.
package prcg_pkg;

  localparam int unsigned ColW   = 12;
  localparam int unsigned CoefW  = 24;
  localparam int unsigned NormW  = 18;
  localparam int unsigned DimW   = 13;
  localparam int unsigned InvW   = 17;
  localparam int unsigned DegW   = 3;
  localparam int unsigned IdxW   = 5;
  localparam int unsigned CfgAW  = 3;
  localparam int unsigned CfgDW  = 17;
  localparam int unsigned ProdW  = CoefW + NormW;

  // Highest polynomial degree; the degree register and the term index are sized for it.
  localparam int MaxDegree = 6;

  localparam logic signed [NormW-1:0] OneQ16 = 18'sd65536;
  localparam logic signed [CoefW-1:0] S24Max = 24'sh7fffff;
  localparam logic signed [CoefW-1:0] S24Min = 24'sh800000;

  // Configuration register indexes.
  localparam logic [CfgAW-1:0] RegWidth     = 3'd0;
  localparam logic [CfgAW-1:0] RegHeight    = 3'd1;
  localparam logic [CfgAW-1:0] RegInvWidth  = 3'd2;
  localparam logic [CfgAW-1:0] RegInvHeight = 3'd3;
  localparam logic [CfgAW-1:0] RegDegree    = 3'd4;

  // Operation codes of an input transaction.
  localparam logic OpLoad  = 1'b0;
  localparam logic OpPixel = 1'b1;

  // Sideband that travels with each transaction down the pipeline.
  typedef struct packed {
    logic                    vld;
    logic                    op;
    logic [IdxW-1:0]         idx;
    logic signed [CoefW-1:0] cx;
    logic signed [CoefW-1:0] cy;
    logic [ColW-1:0]         col;
    logic [ColW-1:0]         row;
  } side_t;

  // Rounds a product of two Q16 values to Q16, half up.
  function automatic logic signed [NormW-1:0] rnd_q16(input logic signed [2*NormW-1:0] p);
    logic signed [2*NormW:0] s;
    s = {p[2*NormW-1], p} + (2*NormW+1)'(32768);
    return s[NormW+15:16];
  endfunction

endpackage

// ===== rtl/polynomial_remap_coordinate_generator.sv =====
// Top level of the polynomial remap coordinate generator: a fully pipelined evaluator.
// Depends on prcg_pkg for widths, register indexes, the sideband type and rounding.
//
//  channel | signals                                           | direction
//  --------+---------------------------------------------------+----------
//  input   | in_valid_i, in_ready_o, operation_i .. pixel_row_i | in
//  output  | out_valid_o, out_ready_i, source_x_o .. saturated_o| out
//  config  | cfg_we_i, cfg_addr_i, cfg_data_i                  | in
//
// One transaction enters per cycle while the output is not stalled. It passes the
// normalizing stage, the power multipliers, the term stage and the registered adder tree.
// Reset clears valid bits and loads the register reset values; table entries stay
// undefined until loaded. A stall at the output freezes every stage together.
module polynomial_remap_coordinate_generator #(
  parameter int MAX_DIM    = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [prcg_pkg::CfgAW-1:0]      cfg_addr_i,
  input  logic [prcg_pkg::CfgDW-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            operation_i,
  input  logic [prcg_pkg::IdxW-1:0]       term_index_i,
  input  logic signed [prcg_pkg::CoefW-1:0] coeff_x_value_i,
  input  logic signed [prcg_pkg::CoefW-1:0] coeff_y_value_i,
  input  logic [prcg_pkg::ColW-1:0]       pixel_col_i,
  input  logic [prcg_pkg::ColW-1:0]       pixel_row_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [prcg_pkg::CoefW-1:0] source_x_o,
  output logic signed [prcg_pkg::CoefW-1:0] source_y_o,
  output logic                            saturated_o
);
  import prcg_pkg::*;

  localparam int NT     = (MaxDegree + 1) * (MaxDegree + 2) / 2;
  localparam int LEVELS = $clog2(NT);
  localparam int AccW   = ProdW + LEVELS + 1;
  localparam int OutW   = AccW + 1;
  localparam logic [14:0] MaxDim = 15'(MAX_DIM);

  function automatic int lvl_cnt(input int l);
    return (NT + (1 << l) - 1) >> l;
  endfunction

  // Configuration registers.
  logic [DimW-1:0] width_q, height_q;
  logic [InvW-1:0] inv_w_q, inv_h_q;
  logic [DegW-1:0] deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd4096;
      height_q <= 13'd4096;
      inv_w_q  <= 17'd16;
      inv_h_q  <= 17'd16;
      deg_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegWidth:     width_q  <= cfg_data_i[DimW-1:0];
        RegHeight:    height_q <= cfg_data_i[DimW-1:0];
        RegInvWidth:  inv_w_q  <= cfg_data_i;
        RegInvHeight: inv_h_q  <= cfg_data_i;
        RegDegree:    deg_q    <= cfg_data_i[DegW-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves when the output register is free or being drained.
  logic en;
  logic out_vld_q;
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // Normalization of one coordinate to Q16, clamped to [-1, 1].
  function automatic logic signed [NormW-1:0] norm(input logic [ColW-1:0] pix,
                                                   input logic [DimW-1:0] dim,
                                                   input logic [InvW-1:0] inv);
    logic [14:0]        d;
    logic signed [15:0] diff;
    logic signed [33:0] p;
    d    = ({2'b00, dim} > MaxDim) ? MaxDim : {2'b00, dim};
    diff = $signed({3'b000, pix, 1'b0}) - $signed({1'b0, d});
    p    = diff * $signed({1'b0, inv});
    if (p > 34'sd65536) return OneQ16;
    else if (p < -34'sd65536) return -OneQ16;
    else return p[NormW-1:0];
  endfunction

  // Stage 0 normalizes; stages 1..MaxDegree each form the next power of x and y.
  side_t                   pw_side_q [0:MaxDegree];
  logic signed [NormW-1:0] xn_q      [0:MaxDegree];
  logic signed [NormW-1:0] yn_q      [0:MaxDegree];
  logic signed [NormW-1:0] xp_q      [0:MaxDegree][0:MaxDegree];
  logic signed [NormW-1:0] yp_q      [0:MaxDegree][0:MaxDegree];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_side_q[0] <= '0;
    end else if (en) begin
      pw_side_q[0] <= '{vld: in_valid_i, op: operation_i, idx: term_index_i,
                        cx: coeff_x_value_i, cy: coeff_y_value_i,
                        col: pixel_col_i, row: pixel_row_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xn_q[0] <= norm(pixel_col_i, width_q, inv_w_q);
      yn_q[0] <= norm(pixel_row_i, height_q, inv_h_q);
      for (int j = 0; j <= MaxDegree; j++) begin
        xp_q[0][j] <= OneQ16;
        yp_q[0][j] <= OneQ16;
      end
    end
  end

  for (genvar s = 1; s <= MaxDegree; s++) begin : g_pow
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pw_side_q[s] <= '0;
      end else if (en) begin
        pw_side_q[s] <= pw_side_q[s-1];
      end
    end

    // Earlier powers pass through; power s is formed here.
    always_ff @(posedge clk_i) begin
      if (en) begin
        xn_q[s] <= xn_q[s-1];
        yn_q[s] <= yn_q[s-1];
        for (int j = 0; j <= MaxDegree; j++) begin
          if (j == s) begin
            xp_q[s][j] <= rnd_q16(xp_q[s-1][s-1] * xn_q[s-1]);
            yp_q[s][j] <= rnd_q16(yp_q[s-1][s-1] * yn_q[s-1]);
          end else begin
            xp_q[s][j] <= xp_q[s-1][j];
            yp_q[s][j] <= yp_q[s-1][j];
          end
        end
      end
    end
  end

  // Term stage: every monomial x^i * y^(t-i), zero above the configured degree.
  side_t                   tm_side_q;
  logic signed [NormW-1:0] term_q [0:NT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tm_side_q <= '0;
    end else if (en) begin
      tm_side_q <= pw_side_q[MaxDegree];
    end
  end

  for (genvar t = 0; t <= MaxDegree; t++) begin : g_deg
    for (genvar i = 0; i <= t; i++) begin : g_term
      always_ff @(posedge clk_i) begin
        if (en) begin
          if (t <= int'(deg_q)) begin
            term_q[t*(t+1)/2+i] <= rnd_q16(xp_q[MaxDegree][i] * yp_q[MaxDegree][t-i]);
          end else begin
            term_q[t*(t+1)/2+i] <= '0;
          end
        end
      end
    end
  end

  // Coefficient tables, written as a load transaction leaves the term stage.
  logic signed [CoefW-1:0] cx_tab_q [0:NT-1];
  logic signed [CoefW-1:0] cy_tab_q [0:NT-1];

  for (genvar k = 0; k < NT; k++) begin : g_tab
    always_ff @(posedge clk_i) begin
      if (en && tm_side_q.vld && tm_side_q.op == OpLoad && int'(tm_side_q.idx) == k) begin
        cx_tab_q[k] <= tm_side_q.cx;
        cy_tab_q[k] <= tm_side_q.cy;
      end
    end
  end

  // Coefficient products form level 0 of the registered adder tree.
  side_t                 tr_side_q [0:LEVELS];
  logic signed [AccW-1:0] sx_q     [0:LEVELS][0:NT-1];
  logic signed [AccW-1:0] sy_q     [0:LEVELS][0:NT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tr_side_q[0] <= '0;
    end else if (en) begin
      tr_side_q[0] <= tm_side_q;
    end
  end

  // Terms above the configured degree contribute nothing, whatever their table entry holds.
  for (genvar t = 0; t <= MaxDegree; t++) begin : g_mul_deg
    for (genvar i = 0; i <= t; i++) begin : g_mul
      localparam int K = t * (t + 1) / 2 + i;
      logic signed [ProdW-1:0] px, py;
      assign px = cx_tab_q[K] * term_q[K];
      assign py = cy_tab_q[K] * term_q[K];

      always_ff @(posedge clk_i) begin
        if (en) begin
          if (t <= int'(deg_q)) begin
            sx_q[0][K] <= AccW'(px);
            sy_q[0][K] <= AccW'(py);
          end else begin
            sx_q[0][K] <= '0;
            sy_q[0][K] <= '0;
          end
        end
      end
    end
  end

  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tr_side_q[l] <= '0;
      end else if (en) begin
        tr_side_q[l] <= tr_side_q[l-1];
      end
    end

    for (genvar j = 0; j < lvl_cnt(l); j++) begin : g_add
      if (2*j+1 < lvl_cnt(l-1)) begin : g_pair
        always_ff @(posedge clk_i) begin
          if (en) begin
            sx_q[l][j] <= sx_q[l-1][2*j] + sx_q[l-1][2*j+1];
            sy_q[l][j] <= sy_q[l-1][2*j] + sy_q[l-1][2*j+1];
          end
        end
      end else begin : g_pass
        always_ff @(posedge clk_i) begin
          if (en) begin
            sx_q[l][j] <= sx_q[l-1][2*j];
            sy_q[l][j] <= sy_q[l-1][2*j];
          end
        end
      end
    end
  end

  // Final stage: round the sums to Q8, subtract from the pixel and saturate.
  function automatic logic signed [OutW-1:0] src(input logic [ColW-1:0] pix,
                                                 input logic signed [AccW-1:0] acc);
    logic signed [AccW:0] r;
    r = ($signed({acc[AccW-1], acc}) + (AccW+1)'(32768)) >>> 16;
    return $signed(OutW'({pix, 8'h00})) - r;
  endfunction

  logic signed [OutW-1:0] fx, fy;
  logic                   sat_x, sat_y;
  logic signed [CoefW-1:0] qx, qy;

  always_comb begin
    fx    = src(tr_side_q[LEVELS].col, sx_q[LEVELS][0]);
    fy    = src(tr_side_q[LEVELS].row, sy_q[LEVELS][0]);
    sat_x = (fx > OutW'(S24Max)) || (fx < OutW'(S24Min));
    sat_y = (fy > OutW'(S24Max)) || (fy < OutW'(S24Min));
    qx    = (fx > OutW'(S24Max)) ? S24Max : (fx < OutW'(S24Min)) ? S24Min : fx[CoefW-1:0];
    qy    = (fy > OutW'(S24Max)) ? S24Max : (fy < OutW'(S24Min)) ? S24Min : fy[CoefW-1:0];
  end

  logic signed [CoefW-1:0] src_x_q, src_y_q;
  logic                    sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= tr_side_q[LEVELS].vld && tr_side_q[LEVELS].op == OpPixel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      src_x_q <= qx;
      src_y_q <= qy;
      sat_q   <= sat_x || sat_y;
    end
  end

  assign out_valid_o = out_vld_q;
  assign source_x_o  = src_x_q;
  assign source_y_o  = src_y_q;
  assign saturated_o = sat_q;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the polynomial remap coordinate generator.
// Drives load and pixel transactions, predicts each remap coordinate and checks the outputs.
// Depends on prcg_pkg and the polynomial_remap_coordinate_generator RTL.
`timescale 1ns / 100ps

module testbench;
  import prcg_pkg::*;

  localparam int NumTerms    = 28;
  localparam int DrainCycles = 40;
  localparam int CycleLimit  = 400000;

  typedef struct {
    logic signed [CoefW-1:0] src_x;
    logic signed [CoefW-1:0] src_y;
    logic                    sat;
  } remap_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CfgAW-1:0]        cfg_addr_i = '0;
  logic [CfgDW-1:0]        cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    operation_i = OpLoad;
  logic [IdxW-1:0]         term_index_i = '0;
  logic signed [CoefW-1:0] coeff_x_value_i = '0;
  logic signed [CoefW-1:0] coeff_y_value_i = '0;
  logic [ColW-1:0]         pixel_col_i = '0;
  logic [ColW-1:0]         pixel_row_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [CoefW-1:0] source_x_o;
  logic signed [CoefW-1:0] source_y_o;
  logic                    saturated_o;

  // Predictor state: registers and coefficient tables.
  int unsigned             img_w = 4096, img_h = 4096, inv_w = 16, inv_h = 16, degree = 0;
  logic signed [CoefW-1:0] x_coeffs[NumTerms];
  logic signed [CoefW-1:0] y_coeffs[NumTerms];

  remap_t      pending_remaps[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatches = 0;
  int          checked = 0;
  int          sent_items = 0;
  int          sat_seen = 0;
  longint      cycles = 0;

  polynomial_remap_coordinate_generator i_dut (.*);

  always #5 clk_i = ~clk_i;

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results pending", cycles, pending_remaps.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver backpressure.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic longint round_q16(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic longint norm_coord(longint pix, int unsigned dim, int unsigned inv);
    longint d;
    longint v;
    d = (dim > 4096) ? 4096 : dim;
    v = (2 * pix - d) * longint'(inv);
    if (v > 65536) v = 65536;
    if (v < -65536) v = -65536;
    return v;
  endfunction

  function automatic longint clip_s24(longint v, ref logic flag);
    if (v > 8388607) begin
      flag = 1'b1;
      return 8388607;
    end
    if (v < -8388608) begin
      flag = 1'b1;
      return -8388608;
    end
    return v;
  endfunction

  // Evaluates the displacement polynomial and forms the source coordinate.
  function automatic remap_t predict_remap(int unsigned col, int unsigned row);
    longint xp[7];
    longint yp[7];
    longint xn, yn, acc_x, acc_y, term;
    int     deg, k;
    logic   flag;
    remap_t r;
    deg = (degree > 6) ? 6 : degree;
    xn = norm_coord(col, img_w, inv_w);
    yn = norm_coord(row, img_h, inv_h);
    xp[0] = 65536;
    yp[0] = 65536;
    for (int t = 1; t <= deg; t++) begin
      xp[t] = round_q16(xp[t-1] * xn);
      yp[t] = round_q16(yp[t-1] * yn);
    end
    acc_x = 0;
    acc_y = 0;
    k = 0;
    for (int t = 0; t <= deg; t++) begin
      for (int i = 0; i <= t; i++) begin
        term = round_q16(xp[i] * yp[t-i]);
        acc_x += longint'(x_coeffs[k]) * term;
        acc_y += longint'(y_coeffs[k]) * term;
        k++;
      end
    end
    flag = 1'b0;
    r.src_x = CoefW'(clip_s24(longint'(col) * 256 - round_q16(acc_x), flag));
    r.src_y = CoefW'(clip_s24(longint'(row) * 256 - round_q16(acc_y), flag));
    r.sat = flag;
    return r;
  endfunction

  // Sends one transaction and updates the prediction when it is accepted.
  task automatic send_item(logic op, int idx, int cx, int cy, int col, int row);
    int gap;
    gap = 0;
    if (send_idle_pct > 0) begin
      while ($urandom_range(99) < send_idle_pct) gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    term_index_i    <= IdxW'(idx);
    coeff_x_value_i <= CoefW'(cx);
    coeff_y_value_i <= CoefW'(cy);
    pixel_col_i     <= ColW'(col);
    pixel_row_i     <= ColW'(row);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_items++;
    if (op == OpLoad) begin
      if (idx < NumTerms) begin
        x_coeffs[idx] = CoefW'(cx);
        y_coeffs[idx] = CoefW'(cy);
      end
    end else begin
      pending_remaps.push_back(predict_remap(col, row));
    end
  endtask

  // Holds the sender off until every expected result has arrived and the pipe is empty.
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_remaps.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgAW-1:0] idx, int unsigned val);
    drain_pipe();
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= CfgDW'(val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      RegWidth:     img_w = val;
      RegHeight:    img_h = val;
      RegInvWidth:  inv_w = val;
      RegInvHeight: inv_h = val;
      RegDegree:    degree = val;
      default: ;
    endcase
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned deg);
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
    write_reg(RegInvWidth, (65536 + w / 2) / w);
    write_reg(RegInvHeight, (65536 + h / 2) / h);
    write_reg(RegDegree, deg);
  endtask

  function automatic int rand_coeff();
    case ($urandom_range(3))
      0: return $signed(24'($urandom));
      1: return $urandom_range(511) - 256;
      default: return $urandom_range(8191) - 4096;
    endcase
  endfunction

  // Output checker: compares each result with the oldest prediction.
  always @(posedge clk_i) begin
    remap_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_remaps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result x=%0d y=%0d", source_x_o, source_y_o);
      end else begin
        want = pending_remaps.pop_front();
        checked++;
        if (saturated_o) sat_seen++;
        if (source_x_o !== want.src_x || source_y_o !== want.src_y || saturated_o !== want.sat)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected x=%0d y=%0d sat=%0b, got x=%0d y=%0d sat=%0b",
                     want.src_x, want.src_y, want.sat, source_x_o, source_y_o, saturated_o);
        end
      end
    end
  end

  // Fills the whole table, including extreme coefficients.
  task automatic test_table_load();
    send_item(OpLoad, 0, 8388607, -8388608, 0, 0);
    send_item(OpLoad, 1, -8388608, 8388607, 4095, 4095);
    for (int i = 2; i < NumTerms; i++) send_item(OpLoad, i, rand_coeff(), rand_coeff(), 0, 0);
    // Loads beyond the table must leave it untouched.
    for (int i = NumTerms; i < 32; i++) send_item(OpLoad, i, rand_coeff(), rand_coeff(), 0, 0);
  endtask

  // Corner pixels at the reset geometry and at extreme settings.
  task automatic test_directed_pixels();
    send_item(OpPixel, 0, 0, 0, 0, 0);
    send_item(OpPixel, 0, 0, 0, 4095, 4095);
    set_geometry(1, 1, 6);
    send_item(OpPixel, 0, 0, 0, 0, 0);
    send_item(OpPixel, 0, 0, 0, 4095, 4095);
    send_item(OpPixel, 0, 0, 0, 2048, 0);
    set_geometry(4096, 4096, 6);
    write_reg(RegInvWidth, 65536);
    write_reg(RegInvHeight, 16);
    send_item(OpPixel, 0, 0, 0, 2048, 2048);
    send_item(OpPixel, 0, 0, 0, 4095, 0);
    send_item(OpPixel, 0, 0, 0, 0, 4095);
    set_geometry(640, 480, 3);
    send_item(OpPixel, 0, 0, 0, 320, 240);
    send_item(OpPixel, 0, 0, 0, 639, 479);
    send_item(OpPixel, 0, 0, 0, 4095, 4095);
  endtask

  // Random traffic with occasional geometry changes and a full drain.
  task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 50)
        set_geometry($urandom_range(4096, 1), $urandom_range(4096, 1), $urandom_range(6));
      if (n % 100 == 75) begin
        write_reg(RegInvWidth, $urandom_range(65536, 16));
        write_reg(RegInvHeight, $urandom_range(65536, 16));
      end
      if ($urandom_range(3) == 0)
        send_item(OpLoad, $urandom_range(31), rand_coeff(), rand_coeff(), $urandom, $urandom);
      else
        send_item(OpPixel, 0, $urandom, $urandom, $urandom_range(4095), $urandom_range(4095));
    end
    drain_pipe();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_load();
    test_directed_pixels();
    test_random_traffic(300, 10, 52);
    test_random_traffic(300, 52, 10);
    test_random_traffic(300, 0, 0);
    drain_pipe();
    $display("Sent %0d transactions; checked %0d remap results (%0d saturated).",
             sent_items, checked, sat_seen);
    $display("Covered table loads, all degrees, extreme geometry and three idle mixes.");
    if (mismatches == 0 && pending_remaps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_remaps.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
